// ----- design/srx_pkg.sv -----
// shared types and constants for the serial frame receiver
`default_nettype none

package srx_pkg;

  // result item kinds
  typedef enum logic [2:0] {
    EV_ACK        = 3'd0,
    EV_NACK       = 3'd1,
    EV_NOT_CONN   = 3'd2,
    EV_PING       = 3'd3,
    EV_PAYLOAD    = 3'd4,
    EV_FRAME_GOOD = 3'd5,
    EV_FRAME_BAD  = 3'd6
  } srx_event_e;

  // configuration register indexes (word address)
  typedef enum logic [2:0] {
    REG_CODE_ACK      = 3'd0,
    REG_CODE_NACK     = 3'd1,
    REG_CODE_NOT_CONN = 3'd2,
    REG_CODE_PING     = 3'd3,
    REG_CODE_DATA     = 3'd4
  } srx_reg_e;

  localparam int unsigned PosW     = 9;
  localparam int unsigned AddrW    = 5;
  localparam logic [15:0] CrcInit  = 16'hFFFF;

  localparam logic [7:0] RstCodeAck     = 8'd0;
  localparam logic [7:0] RstCodeNack    = 8'd1;
  localparam logic [7:0] RstCodeNotConn = 8'd2;
  localparam logic [7:0] RstCodePing    = 8'd3;
  localparam logic [7:0] RstCodeData    = 8'd4;

endpackage

`default_nettype wire

// ----- design/srx_crc16.sv -----
// byte-wide crc-16-ccitt update, polynomial 0x1021, not reflected
`default_nettype none

module srx_crc16 (
  input  wire logic [15:0] crc_i,
  input  wire logic [7:0]  data_i,
  output logic      [15:0] crc_o
);

  logic [15:0] c0;
  logic [15:0] c1;
  logic [15:0] c2;
  logic [15:0] c3;

  // swap bytes and fold in the new byte, then the three xor steps
  always_comb begin
    c0    = {crc_i[7:0], crc_i[15:8]} ^ {8'h00, data_i};
    c1    = c0 ^ {12'h000, c0[7:4]};
    c2    = c1 ^ {c1[3:0], 12'h000};
    c3    = c2 ^ {3'b000, c2[7:0], 5'b00000};
    crc_o = c3;
  end

endmodule

`default_nettype wire

// ----- design/serial_frame_receiver_crc16.sv -----
// serial frame receiver: command decode, length-prefixed payload and crc-16 check
// an item is taken into an input register, then passes into the result register
// throughput: one item per cycle while results are taken; the crc update and the length compare sit in one stage
// the input register takes one more item while a result waits to be taken
// reset: position zero (awaiting a command), running crc 0xffff, code registers to 0..4
// reset clears control state and the code registers; result payload is not reset
`default_nettype none

module serial_frame_receiver_crc16 (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // received bytes
  input  wire logic                     rx_valid_i,
  output logic                          rx_ready_o,
  input  wire logic [7:0]               rx_byte_i,
  // result items
  output logic                          ev_valid_o,
  input  wire logic                     ev_ready_i,
  output logic      [2:0]               event_kind_o,
  output logic      [7:0]               data_byte_o,
  output logic      [7:0]               byte_index_o,
  output logic      [7:0]               frame_length_o,
  output logic      [15:0]              received_crc_o,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [srx_pkg::AddrW-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output logic                          pready
);

  import srx_pkg::*;

  // configuration registers
  logic [7:0] code_ack_q, code_nack_q, code_nc_q, code_ping_q, code_data_q;
  logic       cfg_we;
  srx_reg_e   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = srx_reg_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_ack_q  <= RstCodeAck;
      code_nack_q <= RstCodeNack;
      code_nc_q   <= RstCodeNotConn;
      code_ping_q <= RstCodePing;
      code_data_q <= RstCodeData;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CODE_ACK:      code_ack_q  <= pwdata[7:0];
        REG_CODE_NACK:     code_nack_q <= pwdata[7:0];
        REG_CODE_NOT_CONN: code_nc_q   <= pwdata[7:0];
        REG_CODE_PING:     code_ping_q <= pwdata[7:0];
        REG_CODE_DATA:     code_data_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      REG_CODE_ACK:      prdata = {24'h0, code_ack_q};
      REG_CODE_NACK:     prdata = {24'h0, code_nack_q};
      REG_CODE_NOT_CONN: prdata = {24'h0, code_nc_q};
      REG_CODE_PING:     prdata = {24'h0, code_ping_q};
      REG_CODE_DATA:     prdata = {24'h0, code_data_q};
      default:           prdata = 32'h0;
    endcase
  end

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       adv;

  assign adv        = in_valid_q && (!ev_valid_o || ev_ready_i);
  assign rx_ready_o = !in_valid_q || adv;

  always_comb begin
    in_valid_d = in_valid_q;
    if (rx_valid_i && rx_ready_o) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && rx_ready_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // frame state
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      len_q, len_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crc_lo_q, crc_lo_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [PosW-1:0] len_plus2;
  logic [PosW-1:0] pos_inc;
  logic [PosW-1:0] idx_full;
  logic [15:0]     crc_in;
  logic [15:0]     crc_next;
  logic [15:0]     rx_crc;

  assign len_plus2 = {1'b0, len_q} + PosW'(2);
  assign pos_inc   = pos_q + PosW'(1);
  assign idx_full  = pos_q - PosW'(2);
  assign rx_crc    = {in_byte_q, crc_lo_q};
  assign crc_in    = (pos_q == '0) ? CrcInit : crc_q;

  srx_crc16 u_crc (
    .crc_i  (crc_in),
    .data_i (in_byte_q),
    .crc_o  (crc_next)
  );

  // result register
  logic        ev_valid_q, ev_valid_d;
  srx_event_e  kind_q, kind_d;
  logic [7:0]  data_q, data_d;
  logic [7:0]  idx_q, idx_d;
  logic [7:0]  flen_q, flen_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic        emit;

  // one pass over the byte in the input register
  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    crc_d    = crc_q;
    crc_lo_d = crc_lo_q;
    cmd_d    = cmd_q;
    emit     = 1'b0;
    kind_d   = kind_q;
    data_d   = in_byte_q;
    idx_d    = 8'h00;
    flen_d   = 8'h00;
    rcrc_d   = 16'h0000;
    if (pos_q == '0) begin
      // command byte, first match wins
      if (in_byte_q == code_ack_q) begin
        emit   = 1'b1;
        kind_d = EV_ACK;
      end else if (in_byte_q == code_nack_q) begin
        emit   = 1'b1;
        kind_d = EV_NACK;
      end else if (in_byte_q == code_nc_q) begin
        emit   = 1'b1;
        kind_d = EV_NOT_CONN;
      end else if (in_byte_q == code_ping_q) begin
        emit   = 1'b1;
        kind_d = EV_PING;
      end else if (in_byte_q == code_data_q) begin
        cmd_d = in_byte_q;
        crc_d = crc_next;
        pos_d = PosW'(1);
      end
    end else if (pos_q == PosW'(1)) begin
      // length byte
      len_d = in_byte_q;
      crc_d = crc_next;
      pos_d = PosW'(2);
    end else if (pos_q < len_plus2) begin
      // payload byte
      crc_d  = crc_next;
      pos_d  = pos_inc;
      emit   = 1'b1;
      kind_d = EV_PAYLOAD;
      idx_d  = idx_full[7:0];
      flen_d = len_q;
    end else if (pos_q == len_plus2) begin
      // low crc byte
      crc_lo_d = in_byte_q;
      pos_d    = pos_inc;
    end else begin
      // high crc byte closes the frame
      emit   = 1'b1;
      kind_d = (rx_crc == crc_q) ? EV_FRAME_GOOD : EV_FRAME_BAD;
      data_d = cmd_q;
      flen_d = len_q;
      rcrc_d = rx_crc;
      pos_d  = '0;
      crc_d  = CrcInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= 8'h00;
      crc_q    <= CrcInit;
      crc_lo_q <= 8'h00;
      cmd_q    <= 8'h00;
    end else if (adv) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      crc_q    <= crc_d;
      crc_lo_q <= crc_lo_d;
      cmd_q    <= cmd_d;
    end
  end

  // result handshake
  always_comb begin
    ev_valid_d = ev_valid_q;
    if (adv) begin
      ev_valid_d = emit;
    end else if (ev_ready_i) begin
      ev_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else begin
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      kind_q <= kind_d;
      data_q <= data_d;
      idx_q  <= idx_d;
      flen_q <= flen_d;
      rcrc_q <= rcrc_d;
    end
  end

  assign ev_valid_o     = ev_valid_q;
  assign event_kind_o   = kind_q;
  assign data_byte_o    = data_q;
  assign byte_index_o   = idx_q;
  assign frame_length_o = flen_q;
  assign received_crc_o = rcrc_q;

  // checks
  a_stall_needs_full_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_ready_o |-> (in_valid_q && ev_valid_o && !ev_ready_i))
    else $error("input stalled without a waiting item");

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= len_plus2 + PosW'(1))
    else $error("byte position beyond end of frame");

  a_crc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (crc_q == CrcInit))
    else $error("running crc not at initial value between frames");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && pos_q > len_plus2) |=> (pos_q == '0 && ev_valid_o))
    else $error("frame end did not return to command state with status");

endmodule

`default_nettype wire

// ----- dv/tb_serial_frame_receiver_crc16.sv -----
// testbench for the serial frame receiver: directed and random byte streams, checked against a local model
`default_nettype none

module tb_serial_frame_receiver_crc16;
  import srx_pkg::*;

  localparam int unsigned NumCodeRegs  = 5;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned SettleCycles = 4;

  // one result item as the block gives it
  typedef struct packed {
    srx_event_e  kind;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [7:0]  length;
    logic [15:0] crc;
  } frame_event_t;

  logic              clk_i;
  logic              rst_ni;
  logic              rx_valid_i;
  logic              rx_ready_o;
  logic [7:0]        rx_byte_i;
  logic              ev_valid_o;
  logic              ev_ready_i;
  logic [2:0]        event_kind_o;
  logic [7:0]        data_byte_o;
  logic [7:0]        byte_index_o;
  logic [7:0]        frame_length_o;
  logic [15:0]       received_crc_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // local model of the deframer
  logic [7:0]   code_reg [NumCodeRegs];
  logic [8:0]   frame_pos;
  logic [7:0]   frame_len;
  logic [7:0]   frame_cmd;
  logic [15:0]  frame_crc;
  logic [7:0]   crc_lo_byte;
  frame_event_t pending_events [$];

  int unsigned n_errors     = 0;
  int unsigned items_sent   = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_max      = 6;
  int unsigned cycle_count  = 0;
  bit          hold_off_req = 1'b0;

  serial_frame_receiver_crc16 uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .ev_valid_o     (ev_valid_o),
    .ev_ready_i     (ev_ready_i),
    .event_kind_o   (event_kind_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .received_crc_o (received_crc_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // crc-16-ccitt, msb first, polynomial 0x1021
  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  // advance the model by one received byte and queue the item it gives, if any
  task automatic predict_event(input logic [7:0] b);
    frame_event_t ev;
    logic         hit;
    logic [8:0]   crc_pos;
    ev      = '0;
    hit     = 1'b0;
    crc_pos = {1'b0, frame_len} + 9'd2;
    if (frame_pos == 9'd0) begin
      // command byte: first matching code wins
      hit     = 1'b1;
      ev.data = b;
      if (b == code_reg[REG_CODE_ACK]) begin
        ev.kind = EV_ACK;
      end else if (b == code_reg[REG_CODE_NACK]) begin
        ev.kind = EV_NACK;
      end else if (b == code_reg[REG_CODE_NOT_CONN]) begin
        ev.kind = EV_NOT_CONN;
      end else if (b == code_reg[REG_CODE_PING]) begin
        ev.kind = EV_PING;
      end else begin
        hit = 1'b0;
        if (b == code_reg[REG_CODE_DATA]) begin
          frame_cmd = b;
          frame_crc = crc_ccitt_byte(CrcInit, b);
          frame_pos = 9'd1;
        end
      end
    end else if (frame_pos == 9'd1) begin
      frame_len = b;
      frame_crc = crc_ccitt_byte(frame_crc, b);
      frame_pos = 9'd2;
    end else if (frame_pos < crc_pos) begin
      // payload byte
      hit       = 1'b1;
      ev.kind   = EV_PAYLOAD;
      ev.data   = b;
      ev.index  = 8'(frame_pos - 9'd2);
      ev.length = frame_len;
      frame_crc = crc_ccitt_byte(frame_crc, b);
      frame_pos = frame_pos + 9'd1;
    end else if (frame_pos == crc_pos) begin
      crc_lo_byte = b;
      frame_pos   = frame_pos + 9'd1;
    end else begin
      // crc high byte closes the frame
      hit       = 1'b1;
      ev.crc    = {b, crc_lo_byte};
      ev.kind   = (ev.crc == frame_crc) ? EV_FRAME_GOOD : EV_FRAME_BAD;
      ev.data   = frame_cmd;
      ev.length = frame_len;
      frame_pos = 9'd0;
      frame_crc = CrcInit;
    end
    if (hit) pending_events.push_back(ev);
  endtask

  // offer one item, in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap != 0) begin
        rx_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    predict_event(b);
    items_sent++;
  endtask

  // stop sending and let every expected item drain
  task automatic wait_idle();
    rx_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(input logic [AddrW-1:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // write all five command codes once the block is idle
  task automatic set_codes(input logic [7:0] ack_c, input logic [7:0] nack_c,
                           input logic [7:0] nc_c, input logic [7:0] ping_c,
                           input logic [7:0] data_c);
    logic [7:0] vals [NumCodeRegs];
    vals[REG_CODE_ACK]      = ack_c;
    vals[REG_CODE_NACK]     = nack_c;
    vals[REG_CODE_NOT_CONN] = nc_c;
    vals[REG_CODE_PING]     = ping_c;
    vals[REG_CODE_DATA]     = data_c;
    wait_idle();
    for (int r = 0; r < NumCodeRegs; r++) begin
      apb_write(AddrW'(4 * r), {24'($urandom), vals[r]});
      code_reg[r] = vals[r];
    end
  endtask

  // read back every code register
  task automatic check_codes();
    logic [31:0] rd;
    for (int r = 0; r < NumCodeRegs; r++) begin
      apb_read(AddrW'(4 * r), rd);
      if (rd[7:0] !== code_reg[r]) begin
        $display("%0t: register %0d read: expected %02h, got %02h", $time, r, code_reg[r],
                 rd[7:0]);
        n_errors++;
      end
    end
  endtask

  // one data frame with the current data code; payload random or alternating 00/ff
  task automatic send_frame(input int unsigned len, input bit corrupt, input bit rnd_payload);
    logic [15:0] c;
    logic [7:0]  cmd;
    logic [7:0]  pb;
    cmd = code_reg[REG_CODE_DATA];
    c   = crc_ccitt_byte(CrcInit, cmd);
    send_byte(cmd);
    c = crc_ccitt_byte(c, 8'(len));
    send_byte(8'(len));
    for (int i = 0; i < len; i++) begin
      pb = rnd_payload ? 8'($urandom) : (i[0] ? 8'hFF : 8'h00);
      c  = crc_ccitt_byte(c, pb);
      send_byte(pb);
    end
    if (corrupt) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    send_byte(c[7:0]);
    send_byte(c[15:8]);
  endtask

  // compare each accepted result item with the oldest expected one
  always @(posedge clk_i) begin : event_check
    frame_event_t seen;
    frame_event_t want;
    if (rst_ni && ev_valid_o && ev_ready_i) begin
      seen.kind   = srx_event_e'(event_kind_o);
      seen.data   = data_byte_o;
      seen.index  = byte_index_o;
      seen.length = frame_length_o;
      seen.crc    = received_crc_o;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected item: kind %0d data %02h index %0d len %0d crc %04h",
                 $time, seen.kind, seen.data, seen.index, seen.length, seen.crc);
        n_errors++;
      end else begin
        want = pending_events.pop_front();
        if (seen !== want) begin
          $display("%0t: expected kind %0d data %02h index %0d len %0d crc %04h", $time,
                   want.kind, want.data, want.index, want.length, want.crc);
          $display("%0t:   actual kind %0d data %02h index %0d len %0d crc %04h", $time,
                   seen.kind, seen.data, seen.index, seen.length, seen.crc);
          n_errors++;
        end
      end
    end
  end

  // receiver stalls: runs of random stall density, plus a long hold-off on request
  initial begin : ready_pattern
    int unsigned run_left;
    int unsigned stall_pct;
    run_left  = 0;
    stall_pct = 0;
    ev_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        ev_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      if (run_left == 0) begin
        run_left = $urandom_range(10, 80);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      run_left--;
      ev_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // reset values, command events and unknown codes
  task automatic test_reset_defaults();
    check_codes();
    send_byte(RstCodeAck);
    send_byte(RstCodeNack);
    send_byte(RstCodeNotConn);
    send_byte(RstCodePing);
    send_byte(8'h05);
    send_byte(8'hFF);
  endtask

  // zero length and short frames, good and bad crc
  task automatic test_directed_frames();
    send_frame(0, 1'b0, 1'b0);
    send_frame(0, 1'b1, 1'b0);
    send_frame(2, 1'b0, 1'b0);
    send_frame(1, 1'b1, 1'b1);
  endtask

  // code register writes, writes past the list and colliding codes
  task automatic test_code_registers();
    set_codes(8'hFF, 8'h00, 8'h80, 8'h7F, 8'h55);
    for (int a = NumCodeRegs; a < (1 << AddrW) / 4; a++) begin
      apb_write(AddrW'(4 * a), $urandom);
    end
    check_codes();
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_byte(8'h01);
    send_byte(8'h04);
    send_frame(1, 1'b0, 1'b0);
    // all codes equal: ack wins
    set_codes(8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5);
    send_byte(8'hA5);
    // nack shadows ping and data
    set_codes(8'h11, 8'h3C, 8'h22, 8'h3C, 8'h3C);
    send_byte(8'h3C);
    // ping shadows data
    set_codes(8'h11, 8'h22, 8'h33, 8'h5A, 8'h5A);
    send_byte(8'h5A);
  endtask

  // codes rewritten while a frame is open must not disturb it
  task automatic test_mid_frame_write();
    logic [15:0] c;
    set_codes(8'h00, 8'h01, 8'h02, 8'h03, 8'h04);
    c = crc_ccitt_byte(CrcInit, 8'h04);
    send_byte(8'h04);
    c = crc_ccitt_byte(c, 8'h02);
    send_byte(8'h02);
    set_codes(8'h09, 8'h09, 8'h09, 8'h09, 8'h09);
    c = crc_ccitt_byte(c, 8'h09);
    send_byte(8'h09);
    c = crc_ccitt_byte(c, 8'h09);
    send_byte(8'h09);
    send_byte(c[7:0]);
    send_byte(c[15:8]);
    // the next command byte sees the new codes
    send_byte(8'h09);
  endtask

  // long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    int unsigned saved_gap;
    set_codes(RstCodeAck, RstCodeNack, RstCodeNotConn, RstCodePing, RstCodeData);
    saved_gap    = gap_max;
    gap_max      = 0;
    hold_off_req = 1'b1;
    send_frame(40, 1'b0, 1'b1);
    wait_idle();
    gap_max = saved_gap;
  endtask

  // phases of random traffic, each under its own code setting
  task automatic test_random_traffic();
    int unsigned target;
    int unsigned pick;
    int unsigned len;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_codes(RstCodeAck, RstCodeNack, RstCodeNotConn, RstCodePing, RstCodeData);
        1: set_codes(8'hFF, 8'hFE, 8'h00, 8'h01, 8'h80);
        3: set_codes(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                     8'($urandom_range(0, 7)));
        4: set_codes(8'h7F, 8'h80, 8'hFF, 8'hAA, 8'h00);
        default: set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
      endcase
      target = items_sent + 170;
      // full length payload, index runs to 254
      if (phase == 1 || phase == 4) send_frame(255, phase == 4, 1'b1);
      while (items_sent < target) begin
        // noise may have opened a frame: feed bytes until it closes
        while (frame_pos != 9'd0) send_byte(8'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 8) : $urandom_range(9, 40);
          send_frame(len, $urandom_range(0, 4) == 0, 1'b1);
        end else if (pick < 80) begin
          send_byte(code_reg[$urandom_range(REG_CODE_ACK, REG_CODE_PING)]);
        end else begin
          send_byte(8'($urandom));
        end
      end
    end
  endtask

  initial begin : run
    rst_ni     <= 1'b0;
    rx_valid_i <= 1'b0;
    rx_byte_i  <= 8'h00;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    code_reg[REG_CODE_ACK]      = RstCodeAck;
    code_reg[REG_CODE_NACK]     = RstCodeNack;
    code_reg[REG_CODE_NOT_CONN] = RstCodeNotConn;
    code_reg[REG_CODE_PING]     = RstCodePing;
    code_reg[REG_CODE_DATA]     = RstCodeData;
    frame_pos   = 9'd0;
    frame_len   = 8'h00;
    frame_cmd   = 8'h00;
    frame_crc   = CrcInit;
    crc_lo_byte = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed_frames();
    test_code_registers();
    test_mid_frame_write();
    test_backpressure();
    test_random_traffic();
    wait_idle();

    if (n_errors == 0 && pending_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
